/* sv/ssp_pkg.sv */
// Package for the serial schedule placer: types, constants, state codes.
package ssp_pkg;

	localparam int MaxActivities = 64;
	localparam int NumResources = 4;
	localparam int MaxHorizon = 256;
	localparam int ActW = $clog2(MaxActivities);
	localparam int ResW = (NumResources > 1) ? $clog2(NumResources) : 1;
	localparam int PerW = $clog2(MaxHorizon);
	localparam int TimeW = 9;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] CfgHorizon = 3'd4;

	typedef struct packed {
		logic        mode;
		logic [5:0]  activity_index;
		logic [63:0] predecessor_mask;
		logic [7:0]  duration;
		logic [7:0]  use_res0;
		logic [7:0]  use_res1;
		logic [7:0]  use_res2;
		logic [7:0]  use_res3;
	} in_item_t;

	typedef struct packed {
		logic [8:0] start_time;
		logic [8:0] finish_time;
		logic       placed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_PRED,
		ST_CHECK,
		ST_SEARCH,
		ST_WAIT,
		ST_TEST,
		ST_COMMIT,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_init;
		logic clr_step;
		logic pred_init;
		logic pred_step;
		logic srch_init;
		logic srch_read;
		logic srch_next;
		logic srch_adv;
		logic add_init;
		logic add_step;
		logic store_fin;
		logic set_res;
		logic res_placed;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic clr_done;
		logic pred_done;
		logic bad_idx;
		logic dummy;
		logic no_room;
		logic over;
		logic last_elem;
		logic add_done;
	} stat_t;

endpackage

/* sv/ssp_ctrl.sv */
// Controller state machine for the serial schedule placer.
module ssp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  ssp_pkg::stat_t st,
	output ssp_pkg::cmd_t  cmd
);

	ssp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssp_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ssp_pkg::ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = ssp_pkg::ST_IDLE;
			end
			ssp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.clr_init = 1'b1;
					cmd.pred_init = 1'b1;
					state_d = ssp_pkg::ST_PRED;
				end
			end
			ssp_pkg::ST_PRED: begin
				if (st.is_clear) begin
					cmd.set_res = 1'b1;
					state_d = ssp_pkg::ST_CLEAR;
				end else begin
					cmd.pred_step = 1'b1;
					if (st.pred_done) state_d = ssp_pkg::ST_CHECK;
				end
			end
			ssp_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = ssp_pkg::ST_OUT;
			end
			ssp_pkg::ST_CHECK: begin
				if (st.bad_idx) begin
					cmd.set_res = 1'b1;
					state_d = ssp_pkg::ST_OUT;
				end else if (st.dummy) begin
					cmd.srch_init = 1'b1;
					state_d = ssp_pkg::ST_COMMIT;
				end else begin
					cmd.srch_init = 1'b1;
					state_d = ssp_pkg::ST_SEARCH;
				end
			end
			ssp_pkg::ST_SEARCH: begin
				if (st.no_room) begin
					cmd.set_res = 1'b1;
					state_d = ssp_pkg::ST_OUT;
				end else begin
					cmd.srch_read = 1'b1;
					state_d = ssp_pkg::ST_WAIT;
				end
			end
			ssp_pkg::ST_WAIT: begin
				state_d = ssp_pkg::ST_TEST;
			end
			ssp_pkg::ST_TEST: begin
				if (st.over) begin
					cmd.srch_adv = 1'b1;
					state_d = ssp_pkg::ST_SEARCH;
				end else if (st.last_elem) begin
					state_d = ssp_pkg::ST_COMMIT;
				end else begin
					cmd.srch_next = 1'b1;
					state_d = ssp_pkg::ST_SEARCH;
				end
			end
			ssp_pkg::ST_COMMIT: begin
				cmd.store_fin = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res_placed = 1'b1;
				cmd.add_init = 1'b1;
				state_d = st.dummy ? ssp_pkg::ST_OUT : ssp_pkg::ST_ADD;
			end
			ssp_pkg::ST_ADD: begin
				cmd.add_step = 1'b1;
				if (st.add_done) state_d = ssp_pkg::ST_OUT;
			end
			ssp_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ssp_pkg::ST_IDLE;
			end
			default: state_d = ssp_pkg::ST_IDLE;
		endcase
	end

endmodule

/* sv/ssp_dp.sv */
// Datapath for the serial schedule placer: tables, profile memory, search counters.
module ssp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssp_pkg::in_item_t             in_item,
	input  logic                          cfg_we,
	input  logic [ssp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [15:0]                   cfg_data,
	input  ssp_pkg::cmd_t                 cmd,
	output ssp_pkg::stat_t                st,
	output ssp_pkg::out_item_t            out_item
);

	localparam int NR = ssp_pkg::NumResources;
	localparam int PW = ssp_pkg::PerW;
	localparam int RW = ssp_pkg::ResW;
	localparam int AW = ssp_pkg::ActW;
	localparam int MemW = RW + PW;
	localparam int Depth = NR * ssp_pkg::MaxHorizon;

	logic [15:0] cap_q [4];
	logic [8:0]  hz_cfg_q;
	ssp_pkg::in_item_t item_q;
	logic [8:0]  fin_mem [ssp_pkg::MaxActivities];
	logic [ssp_pkg::MaxActivities-1:0] fin_vld_q;
	logic [8:0]  fin_rd_s1;
	logic        hit_s1;
	logic [15:0] prof_mem [Depth];
	logic [15:0] rd_q;
	logic [MemW:0] clr_q;
	logic [AW:0]   k_q;
	logic [8:0]  es_q;
	logic [9:0]  s_q;
	logic [9:0]  j_q;
	logic [RW-1:0] r_q;
	logic [9:0]  a_q;
	logic [RW-1:0] ar_q;
	logic [MemW-1:0] add_ra;
	ssp_pkg::out_item_t res_q;
	logic [9:0]  hz;
	logic [7:0]  use_r, use_a;
	logic [7:0]  uses [4];
	logic [9:0]  a_end;

	assign uses[0] = item_q.use_res0;
	assign uses[1] = item_q.use_res1;
	assign uses[2] = item_q.use_res2;
	assign uses[3] = item_q.use_res3;
	assign use_r = uses[r_q];
	assign use_a = uses[ar_q];
	assign hz = (hz_cfg_q > 9'(ssp_pkg::MaxHorizon)) ? 10'(ssp_pkg::MaxHorizon)
		: {1'b0, hz_cfg_q};
	assign a_end = s_q + 10'(item_q.duration);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cap_q[i] <= 16'hFFFF;
			hz_cfg_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index < ssp_pkg::CfgHorizon) cap_q[cfg_index[1:0]] <= cfg_data;
			else if (cfg_index == ssp_pkg::CfgHorizon) hz_cfg_q <= cfg_data[8:0];
		end
	end

	// Finish table valid bits; an entry without its bit reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q <= '0;
		end else if (cmd.set_res && item_q.mode) begin
			fin_vld_q <= '0;
		end else if (cmd.store_fin) begin
			fin_vld_q[item_q.activity_index[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_fin) fin_mem[item_q.activity_index[AW-1:0]] <= a_end[8:0];
		if (cmd.pred_step) fin_rd_s1 <= fin_mem[k_q[AW-1:0]];
	end

	// Clear sweep over the profile memory; runs after reset as well.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_init) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !clr_q[MemW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// The add walk reads ahead: the read address is the entry after the write address.
	always_comb begin
		if (cmd.add_init) add_ra = {RW'(0), s_q[PW-1:0]};
		else if (a_q + 1'b1 == a_end) add_ra = {RW'(ar_q + 1'b1), s_q[PW-1:0]};
		else add_ra = {ar_q, PW'(a_q[PW-1:0] + 1'b1)};
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step && !clr_q[MemW]) begin
			prof_mem[clr_q[MemW-1:0]] <= '0;
		end else if (cmd.add_step && use_a != 8'd0) begin
			prof_mem[{ar_q, a_q[PW-1:0]}] <= rd_q + 16'(use_a);
		end
		if (cmd.srch_read) rd_q <= prof_mem[{r_q, j_q[PW-1:0]}];
		else if (cmd.add_init || cmd.add_step) rd_q <= prof_mem[add_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.pred_init) begin
			k_q <= '0;
			es_q <= '0;
			hit_s1 <= 1'b0;
		end else if (cmd.pred_step) begin
			if (!k_q[AW]) k_q <= k_q + 1'b1;
			hit_s1 <= !k_q[AW] && item_q.predecessor_mask[k_q[AW-1:0]] &&
				fin_vld_q[k_q[AW-1:0]];
			if (hit_s1 && fin_rd_s1 > es_q) es_q <= fin_rd_s1;
		end
		if (cmd.srch_init) begin
			s_q <= {1'b0, es_q};
			j_q <= {1'b0, es_q};
			r_q <= '0;
		end else if (cmd.srch_adv) begin
			s_q <= s_q + 1'b1;
			j_q <= s_q + 1'b1;
			r_q <= '0;
		end else if (cmd.srch_next) begin
			if (j_q + 1'b1 == a_end) begin
				j_q <= s_q;
				r_q <= r_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
		if (cmd.add_init) begin
			a_q <= s_q;
			ar_q <= '0;
		end else if (cmd.add_step) begin
			if (a_q + 1'b1 == a_end) begin
				a_q <= s_q;
				ar_q <= ar_q + 1'b1;
			end else begin
				a_q <= a_q + 1'b1;
			end
		end
		if (cmd.set_res) begin
			res_q.placed <= cmd.res_placed;
			res_q.start_time <= cmd.res_placed ? s_q[8:0] : '0;
			res_q.finish_time <= cmd.res_placed ? a_end[8:0] : '0;
		end
	end

	assign st.is_clear = item_q.mode;
	assign st.clr_done = clr_q[MemW];
	assign st.pred_done = k_q[AW];
	assign st.bad_idx = 1'b0;
	assign st.dummy = (item_q.duration == 8'd0);
	assign st.no_room = ({1'b0, a_end} > {1'b0, hz}) || a_end[9];
	assign st.over = (17'(rd_q) + 17'(use_r)) > 17'(cap_q[r_q]);
	assign st.last_elem = (j_q + 1'b1 == a_end) && (r_q == RW'(NR - 1));
	assign st.add_done = (a_q + 1'b1 == a_end) && (ar_q == RW'(NR - 1));
	assign out_item = res_q;

endmodule

/* sv/serial_schedule_placer_core.sv */
// A clear sweeps the whole profile memory; a place scans the finish table for predecessors,
// searches the profile entry by entry, then updates the profile of each resource over the duration.
// Throughput: one transaction at a time; the next is accepted the cycle after the result.
// Reset: capacities 65535, horizon 256, finish times zero; input stalls while a sweep
// zeroes the profile memory.
module serial_schedule_placer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ssp_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssp_pkg::out_item_t           out_data,
	input  logic                         cfg_we,
	input  logic [ssp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [15:0]                  cfg_data
);

	ssp_pkg::cmd_t  cmd;
	ssp_pkg::stat_t st;

	ssp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
	);

	ssp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .st(st),
		.out_item(out_data)
	);

endmodule

/* tb/sv/serial_schedule_placer_checker.sv */
// Checker for the serial schedule placer: predicts each result and compares it.
`timescale 1ns / 1ps
module serial_schedule_placer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  ssp_pkg::in_item_t            in_data,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  ssp_pkg::out_item_t           out_data,
	input  logic                         cfg_we,
	input  logic [ssp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [15:0]                  cfg_data,
	output int                           pending,
	output int                           errors
);

	logic [15:0] capacity [ssp_pkg::NumResources];
	logic [8:0]  horizon;
	logic [15:0] usage [ssp_pkg::NumResources][ssp_pkg::MaxHorizon];
	logic [8:0]  finish_at [ssp_pkg::MaxActivities];
	ssp_pkg::out_item_t placement_q [$];

	function automatic ssp_pkg::out_item_t place_activity(input ssp_pkg::in_item_t it);
		ssp_pkg::out_item_t res;
		int es, hz, d, s, r, j, k;
		int use_units [ssp_pkg::NumResources];
		bit found, ok;
		res = '0;
		found = 0;
		if (it.mode) begin
			foreach (usage[r2, j2]) usage[r2][j2] = '0;
			foreach (finish_at[k2]) finish_at[k2] = '0;
			return res;
		end
		use_units[0] = it.use_res0;
		use_units[1] = it.use_res1;
		use_units[2] = it.use_res2;
		use_units[3] = it.use_res3;
		es = 0;
		for (k = 0; k < ssp_pkg::MaxActivities; k++)
			if (it.predecessor_mask[k] && finish_at[k] > es) es = finish_at[k];
		hz = (horizon > ssp_pkg::MaxHorizon) ? ssp_pkg::MaxHorizon : horizon;
		d = it.duration;
		if (d == 0) begin
			s = es;
			found = 1;
		end else begin
			for (s = es; s + d <= hz; s++) begin
				ok = 1;
				for (r = 0; r < ssp_pkg::NumResources && ok; r++)
					for (j = s; j < s + d && ok; j++)
						if (j >= ssp_pkg::MaxHorizon ||
								usage[r][j] + use_units[r] > capacity[r])
							ok = 0;
				if (ok) begin
					found = 1;
					break;
				end
			end
		end
		if (!found) return res;
		for (r = 0; r < ssp_pkg::NumResources; r++)
			for (j = s; j < s + d && j < ssp_pkg::MaxHorizon; j++)
				usage[r][j] = 16'(usage[r][j] + use_units[r]);
		finish_at[it.activity_index] = 9'(s + d);
		res.start_time = 9'(s);
		res.finish_time = 9'(s + d);
		res.placed = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ssp_pkg::out_item_t want;
		if (!arst_n) begin
			foreach (capacity[r]) capacity[r] = 16'hFFFF;
			horizon = 9'd256;
			foreach (usage[r, j]) usage[r][j] = '0;
			foreach (finish_at[k]) finish_at[k] = '0;
			placement_q.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (placement_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result %p", $realtime, out_data);
				end else begin
					want = placement_q.pop_front();
					if (out_data.start_time !== want.start_time ||
							out_data.finish_time !== want.finish_time ||
							out_data.placed !== want.placed) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch expected %p actual %p",
								$realtime, want, out_data);
					end
				end
			end
			if (in_valid && !in_stall)
				placement_q = {placement_q, place_activity(in_data)};
			if (cfg_we) begin
				if (cfg_index == ssp_pkg::CfgHorizon) horizon = cfg_data[8:0];
				else if (cfg_index < ssp_pkg::CfgHorizon) capacity[cfg_index] = cfg_data;
			end
		end
		pending = placement_q.size();
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the serial schedule placer testbench: stimulus, phases and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int StallLimit = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ssp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ssp_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [ssp_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int pending;
	int errors;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int max_dur = 8;
	int max_use = 255;
	int sent = 0;

	serial_schedule_placer_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	serial_schedule_placer_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_seen != hold_req) begin
			hold_seen++;
			hold_left = 399;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("FAIL serial_schedule_placer_core");
				$finish;
			end
		end
	end

	task automatic send(input ssp_pkg::in_item_t it);
		bit acc;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
			acc = !in_stall;
			@(negedge clk);
		end while (!acc);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic configure(input logic [15:0] c0, c1, c2, c3, input logic [8:0] hz);
		logic [15:0] caps [ssp_pkg::NumResources];
		drain();
		caps = '{c0, c1, c2, c3};
		for (int r = 0; r < ssp_pkg::NumResources; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= ssp_pkg::CfgIdxW'(r);
			cfg_data <= caps[r];
			@(negedge clk);
		end
		cfg_we <= 1'b1;
		cfg_index <= ssp_pkg::CfgHorizon;
		cfg_data <= 16'(hz);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic directed(input logic m, input logic [5:0] idx, input logic [63:0] mask,
			input logic [7:0] dur, input logic [7:0] u);
		ssp_pkg::in_item_t it;
		it = '{m, idx, mask, dur, u, u, u, u};
		send(it);
	endtask

	function automatic ssp_pkg::in_item_t noise_item();
		ssp_pkg::in_item_t it;
		it.mode = ($urandom_range(99) < 30);
		it.activity_index = 6'($urandom);
		it.predecessor_mask = {$urandom, $urandom};
		it.duration = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(max_dur));
		it.use_res0 = 8'($urandom);
		it.use_res1 = 8'($urandom);
		it.use_res2 = 8'($urandom);
		it.use_res3 = 8'($urandom);
		return it;
	endfunction

	function automatic ssp_pkg::in_item_t activity(input int idx);
		ssp_pkg::in_item_t it;
		int pick;
		it = '0;
		it.activity_index = 6'(idx);
		pick = $urandom_range(9);
		if (pick == 0) it.predecessor_mask = {$urandom, $urandom};
		else if (pick > 1)
			repeat ($urandom_range(3)) it.predecessor_mask[$urandom_range(idx)] = 1'b1;
		pick = $urandom_range(99);
		if (pick < 15) it.duration = '0;
		else if (pick < 95) it.duration = 8'($urandom_range(max_dur, 1));
		else it.duration = 8'($urandom);
		it.use_res0 = ($urandom_range(4) == 0) ? '0 : 8'($urandom_range(max_use));
		it.use_res1 = ($urandom_range(4) == 0) ? '0 : 8'($urandom_range(max_use));
		it.use_res2 = ($urandom_range(4) == 0) ? '0 : 8'($urandom_range(max_use));
		it.use_res3 = ($urandom_range(4) == 0) ? '0 : 8'($urandom_range(max_use));
		return it;
	endfunction

	task automatic schedule_phase(input int count, input int idle, input int stall);
		int stop;
		int n;
		ssp_pkg::in_item_t clr;
		send_idle_pct = idle;
		stall_pct = stall;
		stop = sent + count;
		while (sent < stop) begin
			clr = noise_item();
			clr.mode = 1'b1;
			send(clr);
			n = $urandom_range(64, 4);
			for (int i = 0; i < n && sent < stop; i++) begin
				if ($urandom_range(99) < 10) send(noise_item());
				else send(activity(i));
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed(1'b1, 6'd0, '0, 8'd0, 8'd0);
		directed(1'b0, 6'd0, '0, 8'd0, 8'd0);
		directed(1'b0, 6'd1, 64'h1, 8'd255, 8'd255);
		directed(1'b0, 6'd2, 64'h2, 8'd1, 8'd1);
		directed(1'b0, 6'd3, 64'h2, 8'd2, 8'd1);
		directed(1'b0, 6'd63, '1, 8'd0, 8'd255);
		directed(1'b0, 6'd5, 64'h20, 8'd3, 8'd10);
		directed(1'b0, 6'd5, 64'h20, 8'd3, 8'd10);
		configure(16'd300, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd256);
		directed(1'b0, 6'd6, '0, 8'd4, 8'd100);
		directed(1'b1, 6'd63, '1, 8'd255, 8'd255);
		configure(16'd0, 16'd0, 16'd0, 16'd0, 9'd0);
		directed(1'b0, 6'd7, '0, 8'd0, 8'd0);
		directed(1'b0, 6'd8, '0, 8'd1, 8'd0);
		directed(1'b0, 6'd9, '0, 8'd1, 8'd1);
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
		directed(1'b0, 6'd10, '0, 8'd255, 8'd255);
		directed(1'b0, 6'd11, 64'h400, 8'd1, 8'd255);
		directed(1'b0, 6'd12, '0, 8'd255, 8'd0);
		directed(1'b1, 6'd0, '0, 8'd0, 8'd0);

		configure(16'($urandom_range(1000, 200)), 16'($urandom_range(1000, 200)),
			16'($urandom_range(1000, 200)), 16'($urandom_range(1000, 200)), 9'd256);
		max_dur = 8;
		schedule_phase(150, 0, 0);
		hold_req++;
		schedule_phase(150, 0, 0);

		configure(16'd0, 16'($urandom_range(300)), 16'($urandom_range(300)),
			16'($urandom_range(300)), 9'($urandom_range(256, 16)));
		max_use = 150;
		schedule_phase(150, 53, 0);
		drain();
		schedule_phase(150, 53, 0);

		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
		max_use = 255;
		max_dur = 12;
		schedule_phase(300, 0, 53);

		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			9'($urandom_range(40, 1)));
		max_dur = 6;
		schedule_phase(300, 24, 24);

		configure(16'd0, 16'd0, 16'd0, 16'd0, 9'd0);
		schedule_phase(100, 0, 0);

		configure(16'd65535, 16'd1, 16'd65535, 16'd255, 9'd300);
		max_dur = 8;
		schedule_phase(200, 24, 24);

		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (200) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS serial_schedule_placer_core");
		end else begin
			$display("FAIL serial_schedule_placer_core");
		end
		$finish;
	end

endmodule
